// File: sv/pidaw_pkg.sv
// ----------------------------------------------------------------------------
// pidaw_pkg
// Shared widths, register indexes, command codes and types for the PID
// controller with integral clamp.
// ----------------------------------------------------------------------------
`default_nettype none

package pidaw_pkg;

  localparam int DATA_W     = 16;
  localparam int GAIN_W     = 24;
  localparam int LIMIT_W    = 31;
  localparam int ERR_W      = DATA_W + 1;
  localparam int DIF_W      = ERR_W + 1;
  localparam int ACC_W      = 32;
  localparam int IDX_W      = 3;
  localparam int CFG_DATA_W = 32;
  localparam int FRAC_W     = 8;

  localparam int PROD_P_W   = GAIN_W + ERR_W;
  localparam int PROD_I_W   = GAIN_W + ACC_W;
  localparam int PROD_D_W   = GAIN_W + DIF_W;
  localparam int TOTAL_W    = PROD_I_W + 2;
  localparam int QUOT_W     = TOTAL_W - FRAC_W;

  localparam logic [IDX_W-1:0] REG_GAIN_PROP   = 3'd0;
  localparam logic [IDX_W-1:0] REG_GAIN_INTEG  = 3'd1;
  localparam logic [IDX_W-1:0] REG_GAIN_DERIV  = 3'd2;
  localparam logic [IDX_W-1:0] REG_INTEG_LIMIT = 3'd3;
  localparam logic [IDX_W-1:0] REG_OUT_LOW     = 3'd4;
  localparam logic [IDX_W-1:0] REG_OUT_HIGH    = 3'd5;
  localparam logic [IDX_W-1:0] REG_AUTO_CLEAR  = 3'd6;

  localparam logic CMD_STEP  = 1'b0;
  localparam logic CMD_CLEAR = 1'b1;

  typedef struct packed {
    logic signed [GAIN_W-1:0] gain_prop;
    logic signed [GAIN_W-1:0] gain_integ;
    logic signed [GAIN_W-1:0] gain_deriv;
    logic        [LIMIT_W-1:0] integ_limit;
    logic signed [DATA_W-1:0] out_low;
    logic signed [DATA_W-1:0] out_high;
    logic                     auto_clear_enable;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    gain_prop:         '0,
    gain_integ:        '0,
    gain_deriv:        '0,
    integ_limit:       '0,
    out_low:           16'sh8000,
    out_high:          16'sh7fff,
    auto_clear_enable: 1'b1
  };

  typedef struct packed {
    logic signed [ERR_W-1:0] err;
    logic signed [ACC_W-1:0] acc;
    logic signed [DIF_W-1:0] dif;
  } terms_t;

  typedef struct packed {
    logic signed [PROD_P_W-1:0] p;
    logic signed [PROD_I_W-1:0] i;
    logic signed [PROD_D_W-1:0] d;
  } products_t;

endpackage

`default_nettype wire

// File: sv/pidaw_if.sv
// ----------------------------------------------------------------------------
// pidaw interfaces
// Valid/ready channels for command items, results and register writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface pidaw_req_if
  import pidaw_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic                     cmd;
  logic signed [DATA_W-1:0] target;
  logic signed [DATA_W-1:0] sensed;

  modport source (output valid, output cmd, output target, output sensed, input ready);
  modport sink   (input valid, input cmd, input target, input sensed, output ready);
endinterface

interface pidaw_rsp_if
  import pidaw_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] drive;

  modport source (output valid, output drive, input ready);
  modport sink   (input valid, input drive, output ready);
endinterface

interface pidaw_cfg_if
  import pidaw_pkg::*;
();
  logic                  valid;
  logic                  ready;
  logic [IDX_W-1:0]      index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// File: sv/pidaw_integ.sv
// ----------------------------------------------------------------------------
// pidaw_integ
// Error, clamped integral and error difference; holds the integral and
// previous error and registers the terms for the multiply stage.
// ----------------------------------------------------------------------------
`default_nettype none

module pidaw_integ
  import pidaw_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     en,
  input  wire logic                     clear,
  input  wire logic signed [DATA_W-1:0] target,
  input  wire logic signed [DATA_W-1:0] sensed,
  input  wire cfg_t                     cfg,
  output terms_t                        terms
);

  logic signed [ACC_W-1:0] accum;
  logic signed [ERR_W-1:0] last_err;

  logic signed [ERR_W-1:0] err;
  logic signed [ACC_W:0]   sum;
  logic signed [ACC_W:0]   pos_lim;
  logic signed [ACC_W:0]   neg_lim;
  logic signed [ACC_W-1:0] clamped;
  logic signed [ACC_W-1:0] accum_next;
  logic signed [DIF_W-1:0] dif;
  logic                    sign_flip;

  always_comb begin
    err     = ERR_W'(target) - ERR_W'(sensed);
    sum     = (ACC_W + 1)'(accum) + (ACC_W + 1)'(err);
    pos_lim = signed'((ACC_W + 1)'(cfg.integ_limit));
    neg_lim = -pos_lim;
    if (sum > pos_lim) begin
      clamped = pos_lim[ACC_W-1:0];
    end else if (sum < neg_lim) begin
      clamped = neg_lim[ACC_W-1:0];
    end else begin
      clamped = sum[ACC_W-1:0];
    end
    sign_flip = (!err[ERR_W-1] && (err != '0) && last_err[ERR_W-1]) ||
                (err[ERR_W-1] && !last_err[ERR_W-1] && (last_err != '0));
    accum_next = (cfg.auto_clear_enable && sign_flip) ? '0 : clamped;
    dif = DIF_W'(err) - DIF_W'(last_err);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      accum    <= '0;
      last_err <= '0;
    end else if (en) begin
      if (clear) begin
        accum    <= '0;
        last_err <= '0;
      end else begin
        accum    <= accum_next;
        last_err <= err;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en && !clear) begin
      terms.err <= err;
      terms.acc <= accum_next;
      terms.dif <= dif;
    end
  end

endmodule

`default_nettype wire

// File: sv/pidaw_scale.sv
// ----------------------------------------------------------------------------
// pidaw_scale
// Sums the three gain products, drops the fraction with truncation toward
// zero and saturates to the configured output bounds.
// ----------------------------------------------------------------------------
`default_nettype none

module pidaw_scale
  import pidaw_pkg::*;
(
  input  wire products_t                prod,
  input  wire cfg_t                     cfg,
  output logic signed [DATA_W-1:0]      drive
);

  logic signed [TOTAL_W-1:0] total;
  logic signed [TOTAL_W-1:0] biased;
  logic signed [QUOT_W-1:0]  quot;
  logic signed [QUOT_W-1:0]  hi;
  logic signed [QUOT_W-1:0]  lo;

  always_comb begin
    total  = TOTAL_W'(prod.p) + TOTAL_W'(prod.i) + TOTAL_W'(prod.d);
    // negative values get a bias so the shift rounds toward zero
    biased = total + signed'({{(TOTAL_W - FRAC_W){1'b0}}, {FRAC_W{total[TOTAL_W-1]}}});
    quot   = signed'(biased[TOTAL_W-1:FRAC_W]);
    hi     = QUOT_W'(cfg.out_high);
    lo     = QUOT_W'(cfg.out_low);
    if (quot > hi) begin
      drive = cfg.out_high;
    end else if (quot < lo) begin
      drive = cfg.out_low;
    end else begin
      drive = quot[DATA_W-1:0];
    end
  end

endmodule

`default_nettype wire

// File: sv/pid_controller_antiwindup.sv
// ----------------------------------------------------------------------------
// pid_controller_antiwindup
// Discrete PID step with clamped integral and sign-change integral clear.
//
// req carries one command per transaction: cmd step computes one control
// step from target and sensed and gives one drive value on rsp; cmd clear
// zeroes the integral and previous error and gives no result.
// cfg writes the gains, integral limit, output bounds and auto-clear flag;
// it is always ready and should be written only while the block is idle.
// Pipeline: input register, integral/error stage, multiply stage, output
// register. A step result reaches rsp through these registers in order;
// one item is accepted every cycle while rsp is not stalled, as the single
// integral update loop closes within the integral/error stage.
// When rsp stalls, the result is held and upstream stages keep filling
// empty slots; req drops ready only once all stages are full.
// Reset empties the pipeline and returns registers and state to defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module pid_controller_antiwindup
  import pidaw_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  pidaw_req_if.sink   req,
  pidaw_rsp_if.source rsp,
  pidaw_cfg_if.sink   cfg
);

  cfg_t cfg_regs;

  logic                     v0;
  logic                     cmd0;
  logic signed [DATA_W-1:0] target0;
  logic signed [DATA_W-1:0] sensed0;
  logic                     v1;
  logic                     v2;
  logic                     out_valid;
  logic signed [DATA_W-1:0] drive;

  terms_t    terms;
  products_t prod;
  logic signed [DATA_W-1:0] drive_next;

  logic rdy1;
  logic rdy2;
  logic rdy3;
  logic adv0;
  logic is_clear;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs <= CFG_RESET;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_GAIN_PROP:   cfg_regs.gain_prop   <= signed'(cfg.data[GAIN_W-1:0]);
        REG_GAIN_INTEG:  cfg_regs.gain_integ  <= signed'(cfg.data[GAIN_W-1:0]);
        REG_GAIN_DERIV:  cfg_regs.gain_deriv  <= signed'(cfg.data[GAIN_W-1:0]);
        REG_INTEG_LIMIT: cfg_regs.integ_limit <= cfg.data[LIMIT_W-1:0];
        REG_OUT_LOW:     cfg_regs.out_low     <= signed'(cfg.data[DATA_W-1:0]);
        REG_OUT_HIGH:    cfg_regs.out_high    <= signed'(cfg.data[DATA_W-1:0]);
        REG_AUTO_CLEAR:  cfg_regs.auto_clear_enable <= cfg.data[0];
        default: ;
      endcase
    end
  end

  assign rdy3      = !out_valid || rsp.ready;
  assign rdy2      = !v2 || rdy3;
  assign rdy1      = !v1 || rdy2;
  assign is_clear  = (cmd0 == CMD_CLEAR);
  assign adv0      = v0 && (is_clear || rdy1);
  assign req.ready = !v0 || adv0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0        <= 1'b0;
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (req.valid && req.ready) begin
        v0 <= 1'b1;
      end else if (adv0) begin
        v0 <= 1'b0;
      end
      if (rdy1) begin
        v1 <= v0 && !is_clear;
      end
      if (rdy2) begin
        v2 <= v1;
      end
      if (rdy3) begin
        out_valid <= v2;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      cmd0    <= req.cmd;
      target0 <= req.target;
      sensed0 <= req.sensed;
    end
  end

  pidaw_integ u_integ (
    .clk    (clk),
    .rst    (rst),
    .en     (adv0),
    .clear  (is_clear),
    .target (target0),
    .sensed (sensed0),
    .cfg    (cfg_regs),
    .terms  (terms)
  );

  always_ff @(posedge clk) begin
    if (v1 && rdy2) begin
      prod.p <= cfg_regs.gain_prop  * terms.err;
      prod.i <= cfg_regs.gain_integ * terms.acc;
      prod.d <= cfg_regs.gain_deriv * terms.dif;
    end
  end

  pidaw_scale u_scale (
    .prod  (prod),
    .cfg   (cfg_regs),
    .drive (drive_next)
  );

  always_ff @(posedge clk) begin
    if (v2 && rdy3) begin
      drive <= drive_next;
    end
  end

  assign rsp.valid = out_valid;
  assign rsp.drive = drive;

endmodule

`default_nettype wire

// File: sv/pidaw_chk.sv
// ----------------------------------------------------------------------------
// pidaw_chk
// Port-level checks for the PID controller, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module pidaw_chk
  import pidaw_pkg::*;
(
  input wire logic                     clk,
  input wire logic                     rst,
  input wire logic                     req_valid,
  input wire logic                     req_ready,
  input wire logic                     rsp_valid,
  input wire logic                     rsp_ready,
  input wire logic signed [DATA_W-1:0] drive
);

  // a result waiting is held until taken
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("result dropped while stalled");

  a_drive_stable: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> $stable(drive))
    else $error("drive changed while stalled");

  // free output side means the input side is free too
  a_accept_free: assert property (@(posedge clk) disable iff (rst)
    rsp_ready |-> req_ready)
    else $error("input blocked with output free");

  // no result can come out within the pipeline depth after reset
  a_reset_empty: assert property (@(posedge clk)
    $past(rst, 1) || $past(rst, 2) || $past(rst, 3) |-> !rsp_valid)
    else $error("result too soon after reset");

endmodule

bind pid_controller_antiwindup pidaw_chk u_pidaw_chk (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req.valid),
  .req_ready (req.ready),
  .rsp_valid (rsp.valid),
  .rsp_ready (rsp.ready),
  .drive     (rsp.drive)
);

`default_nettype wire
